// ===== rtl/pdsm_pkg.sv =====
// Shared constants, register codes and types of the steering and speed mapper.
package pdsm_pkg;

    localparam int DEF_IMAGE_WIDTH  = 640;
    localparam int DEF_IMAGE_HEIGHT = 480;

    localparam int ERR_W      = 10;
    localparam int LINES_W    = 9;
    localparam int GAIN_W     = 20;
    localparam int KD_W       = 16;
    localparam int CMD_W      = 22;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 22;

    localparam int PROD_W     = 25;
    localparam int SPT_W      = 25;
    localparam int KH_W       = 32;
    localparam int T_W        = 33;
    localparam int N_W        = 55;
    localparam int TMAG_W     = 61;
    localparam int G_W        = 55;
    localparam int UI_W       = 50;

    localparam int DIV_REM_W  = 33;
    localparam int DIV_DQ_W   = 60;
    localparam int DIV_STEP_W = 5;
    localparam int TERM_STEPS = 30;
    localparam int MAP_STEPS  = 11;
    localparam int MAP_QW     = 22;

    localparam logic [GAIN_W-1:0] RST_GAIN_LOW   = 20'd0;
    localparam logic [GAIN_W-1:0] RST_GAIN_HIGH  = 20'd102400;
    localparam logic [KD_W-1:0]   RST_DERIV_GAIN = 16'd10;
    localparam logic [CMD_W-1:0]  RST_SPEED_LOW  = 22'd1500000;
    localparam logic [CMD_W-1:0]  RST_SPEED_HIGH = 22'd1700000;
    localparam logic [CMD_W-1:0]  RST_STEER_LOW  = 22'd1000000;
    localparam logic [CMD_W-1:0]  RST_STEER_HIGH = 22'd2000000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_LOW   = 3'd0,
        REG_GAIN_HIGH  = 3'd1,
        REG_DERIV_GAIN = 3'd2,
        REG_SPEED_LOW  = 3'd3,
        REG_SPEED_HIGH = 3'd4,
        REG_STEER_LOW  = 3'd5,
        REG_STEER_HIGH = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_low;
        logic [GAIN_W-1:0] gain_high;
        logic [KD_W-1:0]   kd;
        logic [CMD_W-1:0]  speed_low;
        logic [CMD_W-1:0]  speed_high;
        logic [CMD_W-1:0]  steer_low;
        logic [CMD_W-1:0]  steer_high;
    } t_cfg;

    typedef struct packed {
        logic signed [ERR_W-1:0]  e;
        logic signed [ERR_W:0]    diff;
        logic signed [PROD_W-1:0] prod;
        logic [SPT_W-1:0]         speed_t;
    } t_item;

    typedef struct packed {
        logic                  start;
        logic [DIV_REM_W-1:0]  rem;
        logic [DIV_DQ_W-1:0]   dq;
        logic [DIV_REM_W-1:0]  divisor;
        logic [DIV_STEP_W-1:0] steps;
    } t_div_req;

endpackage

// ===== rtl/pdsm_in_if.sv =====
// Input channel carrying the lateral errors and the valid line count.
interface pdsm_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [pdsm_pkg::ERR_W-1:0]   error_now;
    logic signed [pdsm_pkg::ERR_W-1:0]   error_prev;
    logic [pdsm_pkg::LINES_W-1:0]        valid_lines;

    modport source (output valid, error_now, error_prev, valid_lines, input ready);
    modport sink (input valid, error_now, error_prev, valid_lines, output ready);
endinterface

// ===== rtl/pdsm_out_if.sv =====
// Output channel carrying the steering and speed commands.
interface pdsm_out_if;
    logic                         valid;
    logic                         ready;
    logic [pdsm_pkg::CMD_W-1:0]   steer_command;
    logic [pdsm_pkg::CMD_W-1:0]   speed_command;

    modport source (output valid, steer_command, speed_command, input ready);
    modport sink (input valid, steer_command, speed_command, output ready);
endinterface

// ===== rtl/pdsm_front.sv =====
// Front end: accepts a frame and forms the position product and clamped line square.
module pdsm_front #(
    parameter int IMAGE_WIDTH  = pdsm_pkg::DEF_IMAGE_WIDTH,
    parameter int IMAGE_HEIGHT = pdsm_pkg::DEF_IMAGE_HEIGHT
) (
    pdsm_in_if.sink          i_in,
    input  logic             i_full,
    output logic             o_push,
    output pdsm_pkg::t_item  o_item
);
    import pdsm_pkg::*;

    localparam int HALF = IMAGE_WIDTH / 2;
    localparam int H2   = IMAGE_HEIGHT * IMAGE_HEIGHT;

    logic signed [13:0] x;
    logic signed [13:0] wx;
    logic signed [27:0] prod_full;
    logic [17:0]        lsq;

    always_comb begin
        x         = 14'(i_in.error_now) + 14'(HALF);
        wx        = 14'(IMAGE_WIDTH) - x;
        prod_full = x * wx;
        lsq       = 18'(i_in.valid_lines) * 18'(i_in.valid_lines);
        o_item.e       = i_in.error_now;
        o_item.diff    = 11'(i_in.error_now) - 11'(i_in.error_prev);
        o_item.prod    = PROD_W'(prod_full);
        o_item.speed_t = (32'(lsq) > 32'(H2)) ? SPT_W'(H2) : SPT_W'(lsq);
    end

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;
endmodule

// ===== rtl/pdsm_fifo.sv =====
// Two-entry queue between the front end and the arithmetic back end.
module pdsm_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pdsm_pkg::t_item  i_item,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output pdsm_pkg::t_item  o_item
);
    import pdsm_pkg::*;

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_item  = r_mem[r_rp];
endmodule

// ===== rtl/pdsm_div.sv =====
// Shared restoring divider retiring two quotient bits per cycle.
module pdsm_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pdsm_pkg::t_div_req              i_req,
    output logic                            o_done,
    output logic [pdsm_pkg::DIV_DQ_W-1:0]   o_quot
);
    import pdsm_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_STEP_W-1:0] r_cnt;
    logic [DIV_REM_W-1:0]  r_rem;
    logic [DIV_DQ_W-1:0]   r_dq;
    logic [DIV_REM_W-1:0]  r_div;

    logic [DIV_REM_W:0]    rem1;
    logic [DIV_REM_W:0]    rem2;
    logic [DIV_REM_W-1:0]  mid;
    logic [DIV_REM_W-1:0]  n_rem;
    logic                  b1;
    logic                  b2;

    always_comb begin
        rem1  = {r_rem, r_dq[DIV_DQ_W-1]};
        b1    = (rem1 >= {1'b0, r_div});
        mid   = b1 ? DIV_REM_W'(rem1 - {1'b0, r_div}) : DIV_REM_W'(rem1);
        rem2  = {mid, r_dq[DIV_DQ_W-2]};
        b2    = (rem2 >= {1'b0, r_div});
        n_rem = b2 ? DIV_REM_W'(rem2 - {1'b0, r_div}) : DIV_REM_W'(rem2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.rem;
            r_dq  <= i_req.dq;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dq  <= {r_dq[DIV_DQ_W-3:0], b1, b2};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_dq;
endmodule

// ===== rtl/pdsm_back.sv =====
// Back end: gain schedule, PD law and both range maps, sequenced over the shared divider.
module pdsm_back #(
    parameter int IMAGE_WIDTH  = pdsm_pkg::DEF_IMAGE_WIDTH,
    parameter int IMAGE_HEIGHT = pdsm_pkg::DEF_IMAGE_HEIGHT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pdsm_pkg::t_cfg   i_cfg,
    input  logic             i_empty,
    input  pdsm_pkg::t_item  i_item,
    output logic             o_pop,
    pdsm_out_if.source       o_out
);
    import pdsm_pkg::*;

    localparam int HALF = IMAGE_WIDTH / 2;
    localparam int W2   = IMAGE_WIDTH * IMAGE_WIDTH;
    localparam int H2   = IMAGE_HEIGHT * IMAGE_HEIGHT;
    localparam logic signed [61:0] G_SAT = 62'sh20_0000_0000_0000;

    typedef enum logic [4:0] {
        ST_IDLE, ST_TMUL, ST_TSTART, ST_TDIV, ST_GAIN, ST_LMUL, ST_LSUM, ST_CLAMP,
        ST_SMUL, ST_SSTART, ST_SDIV, ST_SRES, ST_VMUL, ST_VSTART, ST_VDIV, ST_VRES,
        ST_OUT
    } t_state;

    t_state                 r_state;
    t_item                  r_item;
    logic                   r_tneg;
    logic [TMAG_W-1:0]      r_tmag;
    logic [KH_W-1:0]        r_kh;
    logic signed [G_W-1:0]  r_g;
    logic signed [64:0]     r_up;
    logic signed [27:0]     r_ud;
    logic signed [UI_W-1:0] r_ui;
    logic [T_W-1:0]         r_t;
    logic [N_W-1:0]         r_n;
    logic [CMD_W-1:0]       r_steer;
    logic [CMD_W-1:0]       r_speed;
    logic                   r_ovalid;

    t_div_req               div_req;
    logic                   div_done;
    logic [DIV_DQ_W-1:0]    quot;

    logic signed [20:0]     delta;
    logic signed [45:0]     tm;
    logic [45:0]            tabs;
    logic signed [61:0]     kmax_s;
    logic signed [61:0]     q_s;
    logic signed [61:0]     g_full;
    logic signed [G_W-1:0]  g_sat;
    logic signed [65:0]     u;
    logic signed [65:0]     ui_full;
    logic signed [50:0]     kh_s;
    logic signed [50:0]     ui_s;
    logic [T_W-1:0]         t_cl;
    logic [CMD_W-1:0]       steer_span;
    logic [CMD_W-1:0]       speed_span;
    logic                   slot_free;

    always_comb begin
        delta   = $signed({1'b0, i_cfg.gain_high}) - $signed({1'b0, i_cfg.gain_low});
        tm      = delta * r_item.prod;
        tabs    = tm[45] ? 46'(-tm) : 46'(tm);
        kmax_s  = $signed({26'b0, i_cfg.gain_high, 16'b0});
        q_s     = $signed({2'b0, quot});
        g_full  = r_tneg ? kmax_s + q_s : kmax_s - q_s;
        if (g_full > G_SAT) begin
            g_sat = G_W'(G_SAT);
        end else if (g_full < -G_SAT) begin
            g_sat = G_W'(-G_SAT);
        end else begin
            g_sat = G_W'(g_full);
        end
        u       = 66'(r_up) + (66'(r_ud) <<< 16);
        ui_full = (u + (u[65] ? 66'sd65535 : 66'sd0)) >>> 16;
        kh_s    = $signed({19'b0, r_kh});
        ui_s    = 51'(r_ui);
        if (ui_s < -kh_s) begin
            t_cl = '0;
        end else if (ui_s > kh_s) begin
            t_cl = {r_kh, 1'b0};
        end else begin
            t_cl = T_W'(ui_s + kh_s);
        end
        steer_span = i_cfg.steer_high - i_cfg.steer_low;
        speed_span = i_cfg.speed_high - i_cfg.speed_low;
        slot_free  = !r_ovalid || o_out.ready;
    end

    always_comb begin
        div_req         = '0;
        div_req.rem     = r_n[N_W-1:MAP_QW];
        div_req.dq      = {r_n[MAP_QW-1:0], (DIV_DQ_W - MAP_QW)'(0)};
        div_req.steps   = DIV_STEP_W'(MAP_STEPS);
        div_req.divisor = {r_kh, 1'b0};
        unique case (r_state)
            ST_TSTART: begin
                div_req.start   = 1'b1;
                div_req.rem     = DIV_REM_W'(r_tmag[TMAG_W-1]);
                div_req.dq      = r_tmag[DIV_DQ_W-1:0];
                div_req.divisor = DIV_REM_W'(W2);
                div_req.steps   = DIV_STEP_W'(TERM_STEPS);
            end
            ST_SSTART: begin
                div_req.start = 1'b1;
            end
            ST_VSTART: begin
                div_req.start   = 1'b1;
                div_req.divisor = DIV_REM_W'(H2);
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    pdsm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    assign o_pop = (r_state == ST_IDLE) && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && o_out.ready && r_state != ST_OUT) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_item  <= i_item;
                        r_state <= ST_TMUL;
                    end
                end
                ST_TMUL: begin
                    r_tneg  <= tm[45];
                    r_tmag  <= TMAG_W'({tabs, 18'b0});
                    r_kh    <= KH_W'(i_cfg.gain_high * KH_W'(HALF));
                    r_state <= ST_TSTART;
                end
                ST_TSTART: begin
                    r_state <= ST_TDIV;
                end
                ST_TDIV: begin
                    if (div_done) begin
                        r_state <= ST_GAIN;
                    end
                end
                ST_GAIN: begin
                    r_g     <= g_sat;
                    r_state <= ST_LMUL;
                end
                ST_LMUL: begin
                    r_up    <= r_item.e * r_g;
                    r_ud    <= r_item.diff * $signed({1'b0, i_cfg.kd});
                    r_state <= ST_LSUM;
                end
                ST_LSUM: begin
                    r_ui    <= UI_W'(ui_full);
                    r_state <= ST_CLAMP;
                end
                ST_CLAMP: begin
                    r_t     <= t_cl;
                    r_state <= ST_SMUL;
                end
                ST_SMUL: begin
                    r_n     <= N_W'(steer_span * r_t);
                    r_state <= (r_kh == '0) ? ST_SRES : ST_SSTART;
                end
                ST_SSTART: begin
                    r_state <= ST_SDIV;
                end
                ST_SDIV: begin
                    if (div_done) begin
                        r_state <= ST_SRES;
                    end
                end
                ST_SRES: begin
                    if (r_kh == '0) begin
                        r_steer <= i_cfg.steer_low;
                    end else if (i_cfg.steer_high < i_cfg.steer_low) begin
                        r_steer <= (r_t == '0) ? i_cfg.steer_high : i_cfg.steer_low;
                    end else begin
                        r_steer <= i_cfg.steer_low + quot[MAP_QW-1:0];
                    end
                    r_state <= ST_VMUL;
                end
                ST_VMUL: begin
                    r_n     <= N_W'(speed_span * r_item.speed_t);
                    r_state <= ST_VSTART;
                end
                ST_VSTART: begin
                    r_state <= ST_VDIV;
                end
                ST_VDIV: begin
                    if (div_done) begin
                        r_state <= ST_VRES;
                    end
                end
                ST_VRES: begin
                    if (i_cfg.speed_high < i_cfg.speed_low) begin
                        r_speed <= (r_item.speed_t == '0) ? i_cfg.speed_high
                                                          : i_cfg.speed_low;
                    end else begin
                        r_speed <= i_cfg.speed_low + quot[MAP_QW-1:0];
                    end
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (slot_free) begin
                        o_out.steer_command <= r_steer;
                        o_out.speed_command <= r_speed;
                        r_ovalid            <= 1'b1;
                        r_state             <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid = r_ovalid;
endmodule

// ===== rtl/pd_steering_and_speed_mapper.sv =====
// Top level of the gain-scheduled PD steering and speed mapper.
// Each accepted frame yields one transfer of a steering and a speed command. The
// back end uses the shared divider, which retires two quotient bits a cycle: 30
// steps for the scheduled gain term and 11 for each of the two range maps. A
// two-entry queue lets the input side accept frames while the back end works and
// while a result waits on the output. Configuration registers are written through
// the plain write port, by the user only while idle; the block does not enforce it.
module pd_steering_and_speed_mapper #(
    parameter int IMAGE_WIDTH  = pdsm_pkg::DEF_IMAGE_WIDTH,
    parameter int IMAGE_HEIGHT = pdsm_pkg::DEF_IMAGE_HEIGHT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    pdsm_in_if.sink                              i_in,
    pdsm_out_if.source                           o_out,
    input  logic                                 i_cfg_we,
    input  logic [pdsm_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [pdsm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import pdsm_pkg::*;

    t_cfg       r_cfg;
    t_item      front_item;
    t_item      queue_item;
    logic       push;
    logic       pop;
    logic       full;
    logic       empty;
    logic [2:0] r_inflight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_low   <= RST_GAIN_LOW;
            r_cfg.gain_high  <= RST_GAIN_HIGH;
            r_cfg.kd         <= RST_DERIV_GAIN;
            r_cfg.speed_low  <= RST_SPEED_LOW;
            r_cfg.speed_high <= RST_SPEED_HIGH;
            r_cfg.steer_low  <= RST_STEER_LOW;
            r_cfg.steer_high <= RST_STEER_HIGH;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_GAIN_LOW:   r_cfg.gain_low   <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_HIGH:  r_cfg.gain_high  <= i_cfg_data[GAIN_W-1:0];
                REG_DERIV_GAIN: r_cfg.kd         <= i_cfg_data[KD_W-1:0];
                REG_SPEED_LOW:  r_cfg.speed_low  <= i_cfg_data;
                REG_SPEED_HIGH: r_cfg.speed_high <= i_cfg_data;
                REG_STEER_LOW:  r_cfg.steer_low  <= i_cfg_data;
                REG_STEER_HIGH: r_cfg.steer_high <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    pdsm_front #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT)
    ) u_front (
        .i_in   (i_in),
        .i_full (full),
        .o_push (push),
        .o_item (front_item)
    );

    pdsm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_item  (queue_item)
    );

    pdsm_back #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_empty (empty),
        .i_item  (queue_item),
        .o_pop   (pop),
        .o_out   (o_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + 3'(i_in.valid && i_in.ready)
                          - 3'(o_out.valid && o_out.ready);
        end
    end

    a_inflight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= 3'd4)
        else $error("more frames in flight than the design can hold");

    a_out_has_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> r_inflight != 3'd0)
        else $error("result offered without an accepted frame");

    a_steer_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ((o_out.steer_command >= r_cfg.steer_low
                          || o_out.steer_command >= r_cfg.steer_high)
                      && (o_out.steer_command <= r_cfg.steer_low
                          || o_out.steer_command <= r_cfg.steer_high)))
        else $error("steering command outside the servo range");

    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ((o_out.speed_command >= r_cfg.speed_low
                          || o_out.speed_command >= r_cfg.speed_high)
                      && (o_out.speed_command <= r_cfg.speed_low
                          || o_out.speed_command <= r_cfg.speed_high)))
        else $error("speed command outside the ESC range");

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_idx == REG_DERIV_GAIN) |=> r_cfg.kd == $past(i_cfg_data[KD_W-1:0]))
        else $error("derivative gain write not taken");
endmodule

// ===== dv/tb_pdsm_ifs.sv =====
// Testbench copies of the input and output channel interfaces are not needed; this file holds none.
`timescale 1ns / 1ps

// ===== dv/tb_top.sv =====
// Self-checking testbench of the gain-scheduled PD steering and speed mapper.
`timescale 1ns / 1ps
module tb_top;
    import pdsm_pkg::*;

    typedef struct {
        logic signed [ERR_W-1:0] err_now;
        logic signed [ERR_W-1:0] err_prev;
        logic [LINES_W-1:0] lines;
    } t_frame;

    typedef struct {
        logic [CMD_W-1:0] steer;
        logic [CMD_W-1:0] speed;
    } t_command;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    pdsm_in_if in_ch ();
    pdsm_out_if out_ch ();

    pd_steering_and_speed_mapper uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    longint cfg_gain_low, cfg_gain_high, cfg_kd;
    longint cfg_speed_low, cfg_speed_high, cfg_steer_low, cfg_steer_high;

    t_frame pending_frames[$];
    t_command expected_commands[$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off_cycles = 0;
    int errors = 0;

    function automatic longint map_range(longint in_val, longint lo, longint hi,
                                         longint omin, longint omax);
        longint d, span, n;
        d = hi - lo;
        if (d <= 0) return omin;
        if (in_val < lo) in_val = lo;
        if (in_val > hi) in_val = hi;
        span = omax - omin;
        n = span * (in_val - lo);
        if (n < 0) return omin;
        if (n > span * d) return omax;
        return omin + n / d;
    endfunction

    function automatic t_command compute_commands(t_frame f);
        t_command c;
        longint w, h, half, e, ep, x, term, g, u, ui;
        w = DEF_IMAGE_WIDTH;
        h = DEF_IMAGE_HEIGHT;
        half = w / 2;
        e = f.err_now;
        ep = f.err_prev;
        x = e + half;
        term = (4 * (cfg_gain_high - cfg_gain_low) * (x * (w - x)) * 65536) / (w * w);
        g = cfg_gain_high * 65536 - term;
        if (g > (64'sd1 <<< 53)) g = 64'sd1 <<< 53;
        if (g < -(64'sd1 <<< 53)) g = -(64'sd1 <<< 53);
        u = e * g + (e - ep) * cfg_kd * 65536;
        ui = u / 65536;
        c.steer = CMD_W'(map_range(ui, -cfg_gain_high * half, cfg_gain_high * half,
                                   cfg_steer_low, cfg_steer_high));
        c.speed = CMD_W'(map_range(longint'(f.lines) * f.lines, 0, h * h,
                                   cfg_speed_low, cfg_speed_high));
        return c;
    endfunction

    // Driver: offers the head of the queue and predicts on each transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                expected_commands.push_back(compute_commands(pending_frames.pop_front()));
            end
            if ((!in_ch.valid || in_ch.ready)) begin
                if (pending_frames.size() > (in_ch.valid && in_ch.ready ? 0 : 0)
                        && pending_frames.size() > 0
                        && $urandom_range(99) >= send_idle_pct) begin
                    in_ch.valid <= 1'b1;
                    in_ch.error_now <= pending_frames[0].err_now;
                    in_ch.error_prev <= pending_frames[0].err_prev;
                    in_ch.valid_lines <= pending_frames[0].lines;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each output transfer against the oldest prediction.
    always @(posedge i_clk) begin
        t_command want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_commands.size() == 0) begin
                    $error("unexpected transfer steer=%0d speed=%0d",
                           out_ch.steer_command, out_ch.speed_command);
                    errors++;
                end else begin
                    want = expected_commands.pop_front();
                    if (out_ch.steer_command !== want.steer) begin
                        $error("steer_command expected %0d actual %0d",
                               want.steer, out_ch.steer_command);
                        errors++;
                    end
                    if (out_ch.speed_command !== want.speed) begin
                        $error("speed_command expected %0d actual %0d",
                               want.speed, out_ch.speed_command);
                        errors++;
                    end
                end
            end
            if (hold_off_cycles > 0) begin
                hold_off_cycles <= hold_off_cycles - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.error_now = '0;
        in_ch.error_prev = '0;
        in_ch.valid_lines = '0;
        out_ch.ready = 1'b0;
    end

    task automatic write_reg(t_reg_idx idx, longint value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= CFG_DATA_W'(value);
        case (idx)
            REG_GAIN_LOW: cfg_gain_low = value & 20'hFFFFF;
            REG_GAIN_HIGH: cfg_gain_high = value & 20'hFFFFF;
            REG_DERIV_GAIN: cfg_kd = value & 16'hFFFF;
            REG_SPEED_LOW: cfg_speed_low = value & 22'h3FFFFF;
            REG_SPEED_HIGH: cfg_speed_high = value & 22'h3FFFFF;
            REG_STEER_LOW: cfg_steer_low = value & 22'h3FFFFF;
            default: cfg_steer_high = value & 22'h3FFFFF;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_frames.size() > 0 || in_ch.valid || expected_commands.size() > 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic add_frame(int en, int ep, int ln);
        t_frame f;
        f.err_now = ERR_W'(en);
        f.err_prev = ERR_W'(ep);
        f.lines = LINES_W'(ln);
        pending_frames.push_back(f);
    endtask

    task automatic add_random(int count);
        repeat (count) begin
            if ($urandom_range(9) == 0)
                add_frame($urandom_range(1023), $urandom_range(1023), $urandom_range(511));
            else
                add_frame(int'($urandom_range(640)) - 320, int'($urandom_range(640)) - 320,
                          $urandom_range(480));
        end
    endtask

    task automatic random_config();
        write_reg(REG_GAIN_LOW, $urandom_range(20'hFFFFF));
        write_reg(REG_GAIN_HIGH, $urandom_range(3) == 0 ? 0 : $urandom_range(20'hFFFFF));
        write_reg(REG_DERIV_GAIN, $urandom_range(16'hFFFF));
        write_reg(REG_SPEED_LOW, $urandom_range(4000000));
        write_reg(REG_SPEED_HIGH, $urandom_range(4000000));
        write_reg(REG_STEER_LOW, $urandom_range(4000000));
        write_reg(REG_STEER_HIGH, $urandom_range(4000000));
    endtask

    initial begin
        cfg_gain_low = RST_GAIN_LOW;
        cfg_gain_high = RST_GAIN_HIGH;
        cfg_kd = RST_DERIV_GAIN;
        cfg_speed_low = RST_SPEED_LOW;
        cfg_speed_high = RST_SPEED_HIGH;
        cfg_steer_low = RST_STEER_LOW;
        cfg_steer_high = RST_STEER_HIGH;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        add_frame(0, 0, 0);
        add_frame(320, -320, 480);
        add_frame(-320, 320, 240);
        add_frame(511, -512, 511);
        add_frame(-512, 511, 1);
        add_frame(-1, 1, 479);
        add_frame(160, 160, 300);
        wait_drained();

        write_reg(REG_GAIN_HIGH, 0);
        write_reg(REG_STEER_LOW, 4000000);
        write_reg(REG_STEER_HIGH, 0);
        write_reg(REG_SPEED_LOW, 4000000);
        write_reg(REG_SPEED_HIGH, 0);
        add_frame(100, -50, 100);
        add_frame(-320, 0, 480);
        wait_drained();

        write_reg(REG_GAIN_LOW, 20'hFFFFF);
        write_reg(REG_GAIN_HIGH, 20'hFFFFF);
        write_reg(REG_DERIV_GAIN, 16'hFFFF);
        write_reg(REG_SPEED_LOW, 0);
        write_reg(REG_SPEED_HIGH, 4000000);
        write_reg(REG_STEER_LOW, 0);
        write_reg(REG_STEER_HIGH, 4000000);
        add_frame(320, -320, 480);
        add_frame(-320, 320, 0);
        add_frame(511, -512, 511);
        add_frame(-512, 511, 255);
        add_frame(10, 5, 20);
        wait_drained();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 54; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 54; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            if (phase == 2) hold_off_cycles = 1500;
            if (phase != 0) random_config();
            add_random(92);
            wait_drained();
        end

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #8ms;
        $display("simulation failed");
        $finish;
    end
endmodule

// ===== pd_steering_and_speed_mapper.f =====
rtl/pdsm_pkg.sv
rtl/pdsm_in_if.sv
rtl/pdsm_out_if.sv
rtl/pdsm_front.sv
rtl/pdsm_fifo.sv
rtl/pdsm_div.sv
rtl/pdsm_back.sv
rtl/pd_steering_and_speed_mapper.sv
dv/tb_pdsm_ifs.sv
dv/tb_top.sv
